[rtl/core/msd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pkg
// shared widths and constants of the mqtt stream deframer
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int BYTE_W            = 8;
    localparam int TYPE_W            = 4;
    localparam int LEN_W             = 28;
    localparam int GROUP_W           = 7;
    localparam int MAX_LEN_BYTES_DEF = 4;

    localparam logic [BYTE_W-1:0] TYPE_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEN_MASK  = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_BIT  = 8'h80;

endpackage

`default_nettype wire

[rtl/core/msd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_if
// valid/ready channels of the deframer: raw stream bytes in, tagged bytes out
// ----------------------------------------------------------------------------
interface msd_byte_if
    import msd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface msd_frame_if
    import msd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [TYPE_W-1:0] pkt_type;
    logic              is_first;
    logic              in_header;
    logic              header_done;
    logic [LEN_W-1:0]  remaining_len;
    logic              is_last;

    modport source (output valid, output out_byte, output pkt_type, output is_first,
                    output in_header, output header_done, output remaining_len,
                    output is_last, input ready);
    modport sink   (input valid, input out_byte, input pkt_type, input is_first,
                    input in_header, input header_done, input remaining_len,
                    input is_last, output ready);
endinterface

`default_nettype wire

[rtl/core/mqtt_stream_deframer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_stream_deframer_core
// finds mqtt packet boundaries in a byte stream and tags every byte
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  stream   in   stream_byte                                     valid/ready
//  frame    out  out_byte, pkt_type, flags, remaining_len        valid/ready
//
//  one byte per clock sustained while the frame side is ready; a byte passes the
//  input register, then the result register, with the single decode step between them.
//  reset clears the parser state; the first byte after reset is a type byte.
//  a stalled frame side holds the result register; the input register still
//  takes a new request in the cycle the result is taken.
// ----------------------------------------------------------------------------
module mqtt_stream_deframer_core
    import msd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    msd_byte_if.sink       stream,
    msd_frame_if.source    frame
);

    localparam int HP_W = $clog2(MAX_LENGTH_BYTES + 1);
    localparam logic [HP_W-1:0] HP_MAX = HP_W'(MAX_LENGTH_BYTES);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // parser state
    logic [HP_W-1:0]   header_pos_reg, header_pos_next;
    logic              in_payload_reg, in_payload_next;
    logic [TYPE_W-1:0] packet_type_reg, packet_type_next;
    logic [LEN_W-1:0]  length_accum_reg, length_accum_next;
    logic [LEN_W-1:0]  payload_left_reg, payload_left_next;

    // result register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [TYPE_W-1:0] pkt_type_reg;
    logic              is_first_reg, is_first_next;
    logic              in_header_reg, in_header_next;
    logic              header_done_reg, header_done_next;
    logic [LEN_W-1:0]  remaining_len_reg;
    logic              is_last_reg, is_last_next;

    logic              advance;
    logic [4:0]        shift_amt;
    logic [LEN_W-1:0]  group_val;

    assign advance      = in_valid_reg && (!out_valid_reg || frame.ready);
    assign stream.ready = !in_valid_reg || advance;

    // length bytes k = 1..4 land at bit 7*(k-1)
    assign shift_amt = 5'((32'(header_pos_reg) - 32'd1) * 32'(GROUP_W));
    assign group_val = LEN_W'(in_byte_reg & LEN_MASK) << shift_amt;

    always_comb
    begin
        header_pos_next   = header_pos_reg;
        in_payload_next   = in_payload_reg;
        packet_type_next  = packet_type_reg;
        length_accum_next = length_accum_reg;
        payload_left_next = payload_left_reg;
        is_first_next     = 1'b0;
        in_header_next    = 1'b0;
        header_done_next  = 1'b0;
        is_last_next      = 1'b0;

        if (in_payload_reg)
        begin
            payload_left_next = payload_left_reg - LEN_W'(1);
            if (payload_left_next == '0)
            begin
                is_last_next    = 1'b1;
                in_payload_next = 1'b0;
            end
        end
        else if (header_pos_reg == '0)
        begin
            is_first_next     = 1'b1;
            in_header_next    = 1'b1;
            packet_type_next  = TYPE_W'((in_byte_reg & TYPE_MASK) >> 4);
            length_accum_next = '0;
            payload_left_next = '0;
            header_pos_next   = HP_W'(1);
        end
        else
        begin
            in_header_next = 1'b1;
            if (shift_amt < 5'(LEN_W))
            begin
                length_accum_next = length_accum_reg + group_val;
            end
            // continuation on the last allowed length byte is ignored
            if (((in_byte_reg & CONT_BIT) != '0) && (header_pos_reg < HP_MAX))
            begin
                header_pos_next = header_pos_reg + HP_W'(1);
            end
            else
            begin
                header_done_next = 1'b1;
                header_pos_next  = '0;
                if (length_accum_next == '0)
                begin
                    is_last_next = 1'b1;
                end
                else
                begin
                    payload_left_next = length_accum_next;
                    in_payload_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            header_pos_reg   <= '0;
            in_payload_reg   <= 1'b0;
            packet_type_reg  <= '0;
            length_accum_reg <= '0;
            payload_left_reg <= '0;
        end
        else
        begin
            if (stream.ready)
            begin
                in_valid_reg <= stream.valid;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                header_pos_reg   <= header_pos_next;
                in_payload_reg   <= in_payload_next;
                packet_type_reg  <= packet_type_next;
                length_accum_reg <= length_accum_next;
                payload_left_reg <= payload_left_next;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.stream_byte;
        end
        if (advance)
        begin
            out_byte_reg      <= in_byte_reg;
            pkt_type_reg      <= packet_type_next;
            is_first_reg      <= is_first_next;
            in_header_reg     <= in_header_next;
            header_done_reg   <= header_done_next;
            remaining_len_reg <= length_accum_next;
            is_last_reg       <= is_last_next;
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.out_byte      = out_byte_reg;
    assign frame.pkt_type      = pkt_type_reg;
    assign frame.is_first      = is_first_reg;
    assign frame.in_header     = in_header_reg;
    assign frame.header_done   = header_done_reg;
    assign frame.remaining_len = remaining_len_reg;
    assign frame.is_last       = is_last_reg;

    // payload counting and header parsing never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (header_pos_reg == '0))
        else $error("payload counting while header open");

    assert property (@(posedge clk) disable iff (!rst_n)
        header_pos_reg <= HP_MAX)
        else $error("header position past last length byte");

    // a packet start carries no length yet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_first_reg) |->
            (in_header_reg && !header_done_reg && !is_last_reg
             && (remaining_len_reg == '0)))
        else $error("bad flags on first byte");

    // a header byte that ends the packet must also end the header
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_last_reg && in_header_reg) |->
            (header_done_reg && (remaining_len_reg == '0)))
        else $error("header byte ends packet with nonzero length");

    // the payload count was loaded from a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_payload_reg) |-> (payload_left_reg != '0))
        else $error("payload started with zero count");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the mqtt stream deframer: mqtt packets with random
// types, lengths and length encodings are fed in byte by byte, and every
// tagged byte that comes out is checked against a local parser model
// ----------------------------------------------------------------------------
module tb_top;
    import msd_pkg::*;

    localparam int HDR_LEN_BYTES = MAX_LEN_BYTES_DEF;
    localparam int BYTE_TARGET   = 1200;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SHOWN_ERRORS  = 10;

    // opening bytes: zero length packets, one payload byte, a fourth length
    // byte with its continuation flag set, and a two byte encoding of a small length
    localparam logic [BYTE_W-1:0] OPENING_BYTES [25] = '{
        8'h30, 8'h00,
        8'hFF, 8'h00,
        8'h00, 8'h01, 8'hAA,
        8'h12, 8'h80, 8'h80, 8'h80, 8'h80,
        8'hE0, 8'h83, 8'h80, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h55,
        8'h2F, 8'h82, 8'h00, 8'h7E, 8'h81
    };

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [TYPE_W-1:0] ptype;
        logic              first;
        logic              hdr;
        logic              done;
        logic [LEN_W-1:0]  rlen;
        logic              last;
    } frame_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    msd_byte_if  stream_ch ();
    msd_frame_if frame_ch ();

    mqtt_stream_deframer_core #(
        .MAX_LENGTH_BYTES (HDR_LEN_BYTES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .frame  (frame_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [BYTE_W-1:0] stream_backlog [$];
    frame_beat_t       predicted_beats [$];
    int                bytes_taken  = 0;
    int                beat_errors  = 0;
    int                quiet_cycles = 0;

    // parser state of the model
    logic [2:0]       hdr_pos          = '0;
    logic             counting_payload = 1'b0;
    logic [TYPE_W-1:0] cur_type        = '0;
    logic [LEN_W-1:0] len_sum          = '0;
    logic [LEN_W-1:0] bytes_left       = '0;

    function automatic frame_beat_t predict_frame(input logic [BYTE_W-1:0] b);
        frame_beat_t r;
        int          shift_amt;
        r        = '0;
        r.data   = b;
        shift_amt = GROUP_W * (int'(hdr_pos) - 1);
        if (counting_payload)
        begin
            bytes_left = bytes_left - LEN_W'(1);
            if (bytes_left == '0)
            begin
                r.last           = 1'b1;
                counting_payload = 1'b0;
            end
        end
        else if (hdr_pos == 3'd0)
        begin
            r.first    = 1'b1;
            r.hdr      = 1'b1;
            cur_type   = TYPE_W'((b & TYPE_MASK) >> 4);
            len_sum    = '0;
            bytes_left = '0;
            hdr_pos    = 3'd1;
        end
        else
        begin
            r.hdr = 1'b1;
            if (shift_amt < LEN_W)
                len_sum = len_sum + (LEN_W'(b & LEN_MASK) << shift_amt);
            // a continuation flag on the last allowed length byte is ignored
            if ((b & CONT_BIT) != 0 && int'(hdr_pos) < HDR_LEN_BYTES && hdr_pos < 3'd7)
                hdr_pos = hdr_pos + 3'd1;
            else
            begin
                r.done  = 1'b1;
                hdr_pos = 3'd0;
                if (len_sum == '0)
                    r.last = 1'b1;
                else
                begin
                    bytes_left       = len_sum;
                    counting_payload = 1'b1;
                end
            end
        end
        r.ptype = cur_type;
        r.rlen  = len_sum;
        return r;
    endfunction

    // pad adds zero groups to the length encoding, stuck_cont sets the
    // continuation flag on a fourth length byte
    task automatic push_packet(input logic [TYPE_W-1:0] ptype, input int unsigned len,
                               input int unsigned pad, input bit stuck_cont);
        int unsigned       groups;
        int unsigned       total;
        logic [BYTE_W-1:0] lb;
        groups = 1;
        while (groups < HDR_LEN_BYTES && (len >> (GROUP_W * groups)) != 0)
            groups++;
        total = groups + pad;
        if (total > HDR_LEN_BYTES)
            total = HDR_LEN_BYTES;
        stream_backlog.push_back({ptype, 4'($urandom)});
        for (int i = 0; i < total; i++)
        begin
            lb = BYTE_W'((len >> (GROUP_W * i)) & 32'h7F);
            if (i < total - 1 || (stuck_cont && total == HDR_LEN_BYTES))
                lb = lb | CONT_BIT;
            stream_backlog.push_back(lb);
        end
        // payload stops at the end of the stream
        for (int i = 0; i < len && stream_backlog.size() < BYTE_TARGET + 40; i++)
            stream_backlog.push_back(BYTE_W'($urandom));
    endtask

    // three stretches: slow receiver, then slow sender, then full rate
    function automatic int idle_pct(input bit sender);
        if (bytes_taken < BYTE_TARGET / 3)
            return sender ? 30 : 71;
        else if (bytes_taken < 2 * BYTE_TARGET / 3)
            return sender ? 71 : 30;
        else
            return 0;
    endfunction

    // request driver: the byte on the bus stays at the front of the backlog until taken
    always @(posedge clk)
    begin
        if (!rst_n)
            stream_ch.valid <= 1'b0;
        else if (!stream_ch.valid || stream_ch.ready)
        begin
            if (stream_ch.valid)
                void'(stream_backlog.pop_front());
            if (stream_backlog.size() != 0 && $urandom_range(99, 0) >= idle_pct(1'b1))
            begin
                stream_ch.valid       <= 1'b1;
                stream_ch.stream_byte <= stream_backlog[0];
            end
            else
                stream_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            frame_ch.ready <= 1'b0;
        else
            frame_ch.ready <= ($urandom_range(99, 0) >= idle_pct(1'b0));
    end

    always @(posedge clk)
    begin
        frame_beat_t got;
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                got = '{data: frame_ch.out_byte, ptype: frame_ch.pkt_type,
                        first: frame_ch.is_first, hdr: frame_ch.in_header,
                        done: frame_ch.header_done, rlen: frame_ch.remaining_len,
                        last: frame_ch.is_last};
                if (predicted_beats.size() == 0)
                begin
                    beat_errors++;
                    if (beat_errors <= SHOWN_ERRORS)
                        $display("unexpected frame byte %p", got);
                end
                else
                begin
                    if (got !== predicted_beats[0])
                    begin
                        beat_errors++;
                        if (beat_errors <= SHOWN_ERRORS)
                            $display("frame mismatch: expected %p actual %p",
                                     predicted_beats[0], got);
                    end
                    void'(predicted_beats.pop_front());
                end
            end
            if (stream_ch.valid && stream_ch.ready)
            begin
                predicted_beats.push_back(predict_frame(stream_ch.stream_byte));
                bytes_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((stream_ch.valid && stream_ch.ready) || (frame_ch.valid && frame_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("mqtt_stream_deframer_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned len;
        bit          odd;
        stream_ch.valid       = 1'b0;
        stream_ch.stream_byte = '0;
        frame_ch.ready        = 1'b0;
        rst_n                 = 1'b0;

        foreach (OPENING_BYTES[i])
            stream_backlog.push_back(OPENING_BYTES[i]);
        while (stream_backlog.size() < BYTE_TARGET)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 75)
                len = $urandom_range(8, 0);
            else if (pick < 90)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(200, 120);
            odd = ($urandom_range(99, 0) < 25);
            push_packet(TYPE_W'($urandom), len, odd ? $urandom_range(3, 1) : 0,
                        odd && $urandom_range(1, 0));
        end
        // largest remaining length, left open at the end of the stream
        push_packet(4'hA, 32'h0FFF_FFFF, 0, 1'b0);
        while (stream_backlog.size() > BYTE_TARGET + 40)
            void'(stream_backlog.pop_back());

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stream_backlog.size() != 0 || stream_ch.valid || predicted_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (beat_errors == 0)
            $display("mqtt_stream_deframer_core test passed");
        else
            $display("mqtt_stream_deframer_core test failed");
        $finish;
    end

endmodule
